[sv/m3i_pkg.sv]
`timescale 1ns / 1ps

package m3i_pkg;

  // Element width; the adjugate, determinant and divider widths follow from it.
  localparam int ELEM_WIDTH = 16;
  localparam int PW = 2 * ELEM_WIDTH;        // 2x2 product
  localparam int AW = PW + 1;                // adjugate entry
  localparam int DW = ELEM_WIDTH + AW + 2;   // determinant
  localparam int NW = PW;                    // adjugate magnitude, quotient bits
  localparam int QW = 32;                    // result width
  localparam int SW = ((NW > QW) ? NW : QW) + 1;
  localparam int NLANE = 9;

  // adj[k] = e[A]*e[B] - e[C]*e[D], row-major element index
  localparam int ADJ_A [NLANE] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int ADJ_B [NLANE] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int ADJ_C [NLANE] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int ADJ_D [NLANE] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;
  typedef logic signed [AW-1:0] adj_t;
  typedef logic signed [DW-1:0] det_t;
  typedef logic signed [QW-1:0] quot_t;

  typedef struct packed {
    elem_t in_r1c1;
    elem_t in_r1c2;
    elem_t in_r1c3;
    elem_t in_r2c1;
    elem_t in_r2c2;
    elem_t in_r2c3;
    elem_t in_r3c1;
    elem_t in_r3c2;
    elem_t in_r3c3;
  } mat_t;

  typedef struct packed {
    quot_t inv_r1c1;
    quot_t inv_r1c2;
    quot_t inv_r1c3;
    quot_t inv_r2c1;
    quot_t inv_r2c2;
    quot_t inv_r2c3;
    quot_t inv_r3c1;
    quot_t inv_r3c2;
    quot_t inv_r3c3;
    logic  singular;
  } inv_t;

endpackage

[sv/m3i_adj.sv]
`timescale 1ns / 1ps

module m3i_adj (
  input  logic            clk,
  input  logic            en,
  input  m3i_pkg::mat_t   mat,
  output m3i_pkg::adj_t   adj [m3i_pkg::NLANE],
  output m3i_pkg::det_t   det
);

  m3i_pkg::elem_t e [m3i_pkg::NLANE];
  m3i_pkg::elem_t e1 [3];
  m3i_pkg::elem_t e2 [3];
  logic signed [m3i_pkg::PW-1:0] pa [m3i_pkg::NLANE];
  logic signed [m3i_pkg::PW-1:0] pb [m3i_pkg::NLANE];
  m3i_pkg::adj_t a2 [m3i_pkg::NLANE];
  m3i_pkg::adj_t a3 [m3i_pkg::NLANE];
  m3i_pkg::det_t dp [3];

  assign e[0] = mat.in_r1c1;
  assign e[1] = mat.in_r1c2;
  assign e[2] = mat.in_r1c3;
  assign e[3] = mat.in_r2c1;
  assign e[4] = mat.in_r2c2;
  assign e[5] = mat.in_r2c3;
  assign e[6] = mat.in_r3c1;
  assign e[7] = mat.in_r3c2;
  assign e[8] = mat.in_r3c3;

  for (genvar k = 0; k < m3i_pkg::NLANE; k++) begin : g_cof
    always_ff @(posedge clk) begin
      if (en) begin
        pa[k] <= m3i_pkg::PW'(e[m3i_pkg::ADJ_A[k]]) * m3i_pkg::PW'(e[m3i_pkg::ADJ_B[k]]);
        pb[k] <= m3i_pkg::PW'(e[m3i_pkg::ADJ_C[k]]) * m3i_pkg::PW'(e[m3i_pkg::ADJ_D[k]]);
        a2[k] <= m3i_pkg::AW'(pa[k]) - m3i_pkg::AW'(pb[k]);
        a3[k] <= a2[k];
        adj[k] <= a3[k];
      end
    end
  end

  // expand along row 1
  for (genvar j = 0; j < 3; j++) begin : g_row
    always_ff @(posedge clk) begin
      if (en) begin
        e1[j] <= e[j];
        e2[j] <= e1[j];
        dp[j] <= m3i_pkg::DW'(e2[j]) * m3i_pkg::DW'(a2[3*j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det <= dp[0] + dp[1] + dp[2];
    end
  end

endmodule

[sv/m3i_div_lane.sv]
`timescale 1ns / 1ps

module m3i_div_lane (
  input  logic            clk,
  input  logic            en,
  input  m3i_pkg::adj_t   num,
  input  m3i_pkg::det_t   den,
  output m3i_pkg::quot_t  quot,
  output logic            zero
);

  localparam int NW = m3i_pkg::NW;
  localparam int DW = m3i_pkg::DW;
  localparam int SW = m3i_pkg::SW;
  localparam int QW = m3i_pkg::QW;

  logic [NW-1:0] rem [NW+1];
  logic [NW-1:0] nq  [NW+1];
  logic [NW:0]   dlo [NW+1];
  logic          big [NW+1];
  logic          neg [NW+1];
  logic          zr  [NW+1];
  logic [DW-1:0] dm;
  logic [m3i_pkg::AW-1:0] nm;
  logic [SW-1:0] q;

  assign dm = den[DW-1] ? DW'(-den) : DW'(den);
  assign nm = num[m3i_pkg::AW-1] ? m3i_pkg::AW'(-num) : m3i_pkg::AW'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      nq[0]  <= nm[NW-1:0];
      dlo[0] <= dm[NW:0];
      big[0] <= |dm[DW-1:NW+1];
      neg[0] <= num[m3i_pkg::AW-1] ^ den[DW-1];
      zr[0]  <= (dm == '0);
    end
  end

  // one quotient bit per stage
  for (genvar s = 0; s < NW; s++) begin : g_step
    logic [NW:0] t;
    logic        take;
    assign t    = {rem[s], nq[s][NW-1]};
    assign take = !big[s] && (t >= dlo[s]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= take ? NW'(t - dlo[s]) : t[NW-1:0];
        nq[s+1]  <= {nq[s][NW-2:0], take};
        dlo[s+1] <= dlo[s];
        big[s+1] <= big[s];
        neg[s+1] <= neg[s];
        zr[s+1]  <= zr[s];
      end
    end
  end

  assign q = SW'(nq[NW]);

  // saturate to the signed result range
  always_ff @(posedge clk) begin
    if (en) begin
      zero <= zr[NW];
      if (!neg[NW]) begin
        quot <= (q > SW'({1'b0, {(QW-1){1'b1}}})) ? {1'b0, {(QW-1){1'b1}}} : QW'(q);
      end else begin
        quot <= (q > SW'({1'b1, {(QW-1){1'b0}}})) ? {1'b1, {(QW-1){1'b0}}} : QW'(-q);
      end
    end
  end

endmodule

[sv/matrix3_int_inverse.sv]
`timescale 1ns / 1ps

// Integer 3x3 matrix inverse: each item is one signed matrix; the result is
// adj(M) / det(M), each entry truncated toward zero and saturated to 32 bits.
// A matrix with zero determinant gives the identity with singular set. The
// block takes one item per cycle unless stalled and holds up to
// 2*ELEM_WIDTH + 7 items in flight. The pipeline is four cofactor/determinant
// stages, and in each of nine parallel lanes a lane input register, a
// bit-per-stage divider pipeline of 2*ELEM_WIDTH stages and a saturation
// register, then the output register.
// The whole pipeline holds while a finished item waits at a stalled output.
module matrix3_int_inverse (
  input  logic           clk,
  input  logic           rst,
  input  logic           mat_valid,
  output logic           mat_stall,
  input  m3i_pkg::mat_t  mat,
  output logic           inv_valid,
  input  logic           inv_stall,
  output m3i_pkg::inv_t  inv
);

  localparam int LAT = 4 + m3i_pkg::NW + 2;

  logic en;
  logic [LAT-1:0] vld;
  m3i_pkg::adj_t adj [m3i_pkg::NLANE];
  m3i_pkg::det_t det;
  m3i_pkg::quot_t q [m3i_pkg::NLANE];
  logic zero [m3i_pkg::NLANE];

  // advance when the output register is empty or being taken
  assign en = !inv_valid || !inv_stall;
  assign mat_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      inv_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], mat_valid};
      inv_valid <= vld[LAT-1];
    end
  end

  m3i_adj u_adj (
    .clk (clk),
    .en  (en),
    .mat (mat),
    .adj (adj),
    .det (det)
  );

  for (genvar k = 0; k < m3i_pkg::NLANE; k++) begin : g_lane
    m3i_div_lane u_lane (
      .clk  (clk),
      .en   (en),
      .num  (adj[k]),
      .den  (det),
      .quot (q[k]),
      .zero (zero[k])
    );
  end

  // merge lanes; substitute identity on a zero determinant
  always_ff @(posedge clk) begin
    if (en && vld[LAT-1]) begin
      if (zero[0]) begin
        inv.inv_r1c1 <= m3i_pkg::QW'(1);
        inv.inv_r1c2 <= '0;
        inv.inv_r1c3 <= '0;
        inv.inv_r2c1 <= '0;
        inv.inv_r2c2 <= m3i_pkg::QW'(1);
        inv.inv_r2c3 <= '0;
        inv.inv_r3c1 <= '0;
        inv.inv_r3c2 <= '0;
        inv.inv_r3c3 <= m3i_pkg::QW'(1);
        inv.singular <= 1'b1;
      end else begin
        inv.inv_r1c1 <= q[0];
        inv.inv_r1c2 <= q[1];
        inv.inv_r1c3 <= q[2];
        inv.inv_r2c1 <= q[3];
        inv.inv_r2c2 <= q[4];
        inv.inv_r2c3 <= q[5];
        inv.inv_r3c1 <= q[6];
        inv.inv_r3c2 <= q[7];
        inv.inv_r3c3 <= q[8];
        inv.singular <= 1'b0;
      end
    end
  end

endmodule
